// ----- rtl/core/multi_slot_event_timer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// multi_slot_event_timer_unit_assert.svh
// Assertion macros used by the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_EVENT_TIMER_UNIT_ASSERT_SVH
`define MULTI_SLOT_EVENT_TIMER_UNIT_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define MSET_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define MSET_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/mset_pkg.sv -----
// ----------------------------------------------------------------------------
// mset_pkg
// Constants, codes and types of the timer slot table.
// ----------------------------------------------------------------------------
package mset_pkg;

	localparam int SLOTS       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ID_W        = 4;
	localparam int CMP_W       = (IDX_W > ID_W) ? IDX_W : ID_W;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int OP_W        = 2;
	localparam int TIME_W      = 32;
	localparam int COUNT_W     = 16;
	localparam int KIND_W      = 3;

	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [KIND_W-1:0] {
		KIND_FIRED   = 3'd0,
		KIND_CREATED = 3'd1,
		KIND_DELETED = 3'd2,
		KIND_FULL    = 3'd3,
		KIND_INVALID = 3'd4
	} kind_t;

	// Request broadcast to every cell for the whole scan.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] interval;
		logic              one_shot;
		logic [ID_W-1:0]   target;
		logic              fire_en;
	} cmd_t;

	// Scan token handed from cell to cell.
	typedef struct packed {
		logic active;
		logic open;
	} tok_t;

	// Event raised by the cell that holds the token.
	typedef struct packed {
		logic               valid;
		kind_t              kind;
		logic [ID_W-1:0]    id;
		logic [COUNT_W-1:0] count;
	} res_t;

endpackage

// ----- rtl/core/multi_slot_event_timer_unit.sv -----
// ----------------------------------------------------------------------------
// multi_slot_event_timer_unit
// Table of periodic and one-shot timer slots scanned by a token chain.
// ----------------------------------------------------------------------------
// Requests enter on start/busy: a request is taken at a clock edge with start
// high and busy low. operation selects tick (advance time by delta_ticks and
// fire every due slot), create (claim the lowest free slot) or delete (free
// the slot named by slot).
// Each request runs one token down the row of SLOTS cells, one cell a cycle;
// busy stays high until the token has left the last cell, for every operation.
// Results appear on event_kind, slot_id, fire_count and last, each for one
// cycle with result_valid high; results come in ascending slot order, and
// last marks the final one. A tick with nothing due gives no result. The
// receiver cannot stall, so every result is taken in the cycle it is shown.
// Reset clears the time counter, all slot valid bits and the token chain;
// the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`include "multi_slot_event_timer_unit_assert.svh"

module multi_slot_event_timer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] delta_ticks,
	input  logic [31:0] interval_ticks,
	input  logic        one_shot,
	input  logic [3:0]  slot,
	output logic        result_valid,
	output logic [2:0]  event_kind,
	output logic [3:0]  slot_id,
	output logic [15:0] fire_count,
	output logic        last
);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t                         state_q;
	logic [mset_pkg::TIME_W-1:0]    time_q;
	logic [mset_pkg::OP_W-1:0]      op_q;
	logic [mset_pkg::TIME_W-1:0]    interval_q;
	logic                           one_shot_q;
	logic [mset_pkg::ID_W-1:0]      target_q;
	logic [mset_pkg::CNT_W-1:0]     fire_cnt_q;
	mset_pkg::res_t                 pend_q;
	mset_pkg::tok_t                 tok0_q;
	logic                           out_valid_q;
	mset_pkg::kind_t                out_kind_q;
	logic [mset_pkg::ID_W-1:0]      out_id_q;
	logic [mset_pkg::COUNT_W-1:0]   out_count_q;
	logic                           out_last_q;
	mset_pkg::cmd_t                 cmd;
	mset_pkg::tok_t                 tok [mset_pkg::SLOTS+1];
	mset_pkg::res_t                 res_arr [mset_pkg::SLOTS];
	logic [$bits(mset_pkg::res_t)-1:0] hit_vec;
	mset_pkg::res_t                 hit;
	logic [mset_pkg::SLOTS:0]       tok_act;
	logic                           accept;
	logic                           scan_end;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign scan_end = tok[mset_pkg::SLOTS].active;
	assign tok[0]   = tok0_q;

	always_comb begin
		cmd.op       = op_q;
		cmd.now      = time_q;
		cmd.interval = interval_q;
		cmd.one_shot = one_shot_q;
		cmd.target   = target_q;
		cmd.fire_en  = (fire_cnt_q < mset_pkg::CNT_W'(mset_pkg::MAX_RESULTS));
	end

	for (genvar i = 0; i < mset_pkg::SLOTS; i++) begin : g_cell
		mset_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.index   (mset_pkg::IDX_W'(i)),
			.cmd     (cmd),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.res     (res_arr[i])
		);
	end

	// only the cell holding the token can raise an event
	always_comb begin
		hit_vec = '0;
		for (int i = 0; i < mset_pkg::SLOTS; i++)
			hit_vec = hit_vec | res_arr[i];
		hit = mset_pkg::res_t'(hit_vec);
	end

	always_comb begin
		for (int i = 0; i <= mset_pkg::SLOTS; i++)
			tok_act[i] = tok[i].active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			time_q      <= '0;
			tok0_q      <= '0;
			fire_cnt_q  <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= mset_pkg::KIND_FIRED;
			out_id_q    <= '0;
			out_count_q <= '0;
			out_last_q  <= 1'b0;
			op_q        <= '0;
			interval_q  <= '0;
			one_shot_q  <= 1'b0;
			target_q    <= '0;
		end else begin
			out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					tok0_q.active <= accept;
					tok0_q.open   <= accept && (operation == mset_pkg::OP_CREATE);
					if (accept) begin
						state_q       <= ST_SCAN;
						op_q          <= operation;
						interval_q    <= interval_ticks;
						one_shot_q    <= one_shot;
						target_q      <= slot;
						fire_cnt_q    <= '0;
						pend_q        <= '0;
						if (operation == mset_pkg::OP_TICK)
							time_q <= time_q + delta_ticks;
					end
				end
				ST_SCAN: begin
					tok0_q <= '0;
					if (hit.valid) begin
						// release the held event, hold the new one until the next
						if (pend_q.valid) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= pend_q.kind;
							out_id_q    <= pend_q.id;
							out_count_q <= pend_q.count;
							out_last_q  <= 1'b0;
						end
						pend_q <= hit;
						if (op_q == mset_pkg::OP_TICK)
							fire_cnt_q <= fire_cnt_q + mset_pkg::CNT_W'(1);
					end
					if (scan_end) begin
						state_q <= ST_IDLE;
						pend_q  <= '0;
						priority if (pend_q.valid) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= pend_q.kind;
							out_id_q    <= pend_q.id;
							out_count_q <= pend_q.count;
							out_last_q  <= 1'b1;
						end else if (op_q == mset_pkg::OP_CREATE) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= mset_pkg::KIND_FULL;
							out_id_q    <= '0;
							out_count_q <= '0;
							out_last_q  <= 1'b1;
						end else if (op_q == mset_pkg::OP_DELETE) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= mset_pkg::KIND_INVALID;
							out_id_q    <= target_q;
							out_count_q <= '0;
							out_last_q  <= 1'b1;
						end else begin
							out_valid_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					tok0_q  <= '0;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign event_kind   = out_kind_q;
	assign slot_id      = out_id_q;
	assign fire_count   = out_count_q;
	assign last         = out_last_q;

	`MSET_ASSERT(a_accept_busy, accept |=> busy, "request taken but block not busy")
	`MSET_ASSERT(a_one_token, $onehot0(tok_act), "more than one scan token in the chain")
	`MSET_ASSERT(a_last_gap, (result_valid && last) |=> !result_valid,
		"result follows the final result of a request")
	`MSET_NEVER(a_fire_limit, fire_cnt_q > mset_pkg::CNT_W'(mset_pkg::MAX_RESULTS),
		"fire count beyond result limit")
	`MSET_NEVER(a_idle_token, (state_q == ST_IDLE) && (tok_act != '0) && !accept
		&& !$past(accept), "token in the chain while idle")

endmodule

// ----- rtl/core/mset_cell.sv -----
// ----------------------------------------------------------------------------
// mset_cell
// One timer slot: holds its state, acts when the scan token passes.
// ----------------------------------------------------------------------------
module mset_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mset_pkg::IDX_W-1:0] index,
	input  mset_pkg::cmd_t            cmd,
	input  mset_pkg::tok_t            tok_in,
	output mset_pkg::tok_t            tok_out,
	output mset_pkg::res_t            res
);

	logic                             valid_q;
	logic                             one_shot_q;
	logic [mset_pkg::TIME_W-1:0]      interval_q;
	logic [mset_pkg::TIME_W-1:0]      last_q;
	logic [mset_pkg::COUNT_W-1:0]     count_q;
	mset_pkg::tok_t                   tok_q;
	logic [mset_pkg::TIME_W-1:0]      elapsed;
	logic                             due;
	logic                             fire;
	logic                             claim;
	logic                             drop;

	always_comb begin
		elapsed = cmd.now - last_q;
		due     = valid_q && (elapsed >= interval_q);
		fire    = tok_in.active && (cmd.op == mset_pkg::OP_TICK) && due && cmd.fire_en;
		claim   = tok_in.active && (cmd.op == mset_pkg::OP_CREATE) && tok_in.open && !valid_q;
		drop    = tok_in.active && (cmd.op == mset_pkg::OP_DELETE) && valid_q
			&& (mset_pkg::CMP_W'(cmd.target) == mset_pkg::CMP_W'(index));
	end

	// keep every field at zero unless this cell raises an event
	always_comb begin
		res.valid = fire || claim || drop;
		res.kind  = mset_pkg::KIND_FIRED;
		res.id    = '0;
		res.count = '0;
		if (fire) begin
			res.id = mset_pkg::ID_W'(index);
			if (!one_shot_q)
				res.count = count_q;
		end else if (claim) begin
			res.kind = mset_pkg::KIND_CREATED;
			res.id   = mset_pkg::ID_W'(index);
		end else if (drop) begin
			res.kind = mset_pkg::KIND_DELETED;
			res.id   = mset_pkg::ID_W'(index);
		end
	end

	assign tok_out = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q.active <= tok_in.active;
			// close the free-slot search once this cell takes it
			tok_q.open   <= tok_in.open && !claim;
			if (claim)
				valid_q <= 1'b1;
			else if (drop || (fire && one_shot_q))
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			one_shot_q <= cmd.one_shot;
			interval_q <= cmd.interval;
			last_q     <= cmd.now;
			count_q    <= 16'd1;
		end else if (fire) begin
			last_q <= cmd.now;
			if (!one_shot_q && (count_q != mset_pkg::COUNT_MAX))
				count_q <= count_q + 16'd1;
		end
	end

endmodule
